FILE: rtl/tlik_pkg.sv
// Shared constants, config register codes and CORDIC angle table for the
// two-link arm inverse kinematics block. No dependencies.
`default_nettype none

package tlik_pkg;

  localparam int COORD_BITS_DEF = 18;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int                LEN_W     = 16;
  localparam logic [LEN_W-1:0]  LEN_RESET = 16'd13107;  // 0.8 in Q2.14

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_LINK_LENGTH  = 8'd0,
    CFG_SECOND_LINK_LENGTH = 8'd1
  } cfg_idx_t;

  // discriminant factors, their product and its floor root
  localparam int FAC_W = 34;
  localparam int SPLIT = 18;
  localparam int PR_W  = 68;
  localparam int SQ_N  = 34;

  localparam int CORDIC_N = 30;
  localparam int NRM_W    = 39;  // normalized magnitude, top bit at 38
  localparam int XV_W     = 42;  // vectoring datapath
  localparam int PV_W     = 50;  // rotation datapath
  localparam int RND_W    = 18;  // rounded rotation output

  localparam logic [31:0] INV_GAIN = 32'd2608131497;

  function automatic logic [31:0] atan_tab(input int unsigned i);
    case (i)
      0:       return 32'd536870912;
      1:       return 32'd316933406;
      2:       return 32'd167458907;
      3:       return 32'd85004756;
      4:       return 32'd42667331;
      5:       return 32'd21354465;
      6:       return 32'd10679838;
      7:       return 32'd5340245;
      8:       return 32'd2670163;
      9:       return 32'd1335087;
      10:      return 32'd667544;
      11:      return 32'd333772;
      12:      return 32'd166886;
      13:      return 32'd83443;
      14:      return 32'd41722;
      15:      return 32'd20861;
      16:      return 32'd10430;
      17:      return 32'd5215;
      18:      return 32'd2608;
      19:      return 32'd1304;
      20:      return 32'd652;
      21:      return 32'd326;
      22:      return 32'd163;
      23:      return 32'd81;
      24:      return 32'd41;
      25:      return 32'd20;
      26:      return 32'd10;
      27:      return 32'd5;
      28:      return 32'd3;
      29:      return 32'd1;
      default: return 32'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tlik_if.sv
// Valid/ready channel interfaces: target in, arm result out, config write.
// Depends on tlik_pkg for default widths.
`default_nettype none

interface tlik_in_if #(parameter int COORD_BITS = tlik_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink   (input valid, target_x, target_y, output ready);
endinterface

interface tlik_out_if #(
  parameter int COORD_BITS = tlik_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = tlik_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [ANGLE_BITS-1:0]        first_angle;
  logic [ANGLE_BITS-1:0]        second_angle;
  logic signed [COORD_BITS-1:0] elbow_x;
  logic signed [COORD_BITS-1:0] elbow_y;
  logic signed [COORD_BITS-1:0] tip_x;
  logic signed [COORD_BITS-1:0] tip_y;
  logic                         reachable;
  modport source (output valid, first_angle, second_angle, elbow_x, elbow_y,
                  tip_x, tip_y, reachable, input ready);
  modport sink   (input valid, first_angle, second_angle, elbow_x, elbow_y,
                  tip_x, tip_y, reachable, output ready);
endinterface

interface tlik_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tlik_pkg::CFG_IDX_W-1:0]      index;
  logic [tlik_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/two_link_arm_inverse_kinematics.sv
// Top level of the two-link arm IK block: channels, link length registers,
// two-word output buffer. Uses tlik_pkg, tlik_if interfaces and tlik_pipe.
`default_nettype none

// Two-link planar arm inverse kinematics. Each target word (x, y, signed
// Q3.14) yields one result word: both absolute link angles as binary angles
// (a full turn is 2^ANGLE_BITS), elbow and tip positions recomputed from
// those angles (signed Q3.14, saturated), and a reachable flag. Out-of-reach
// targets still give angles, solved with a zero discriminant. Throughput is
// one word per clock while the output buffer has a free slot. The datapath
// holds the 34-stage bit-per-stage square root, the normalizer steps and
// the two 30-stage CORDIC chains (vectoring for atan2, rotation for the
// positions); NRW, the atan2 magnitude width, is at least 39. A two-word
// buffer sits at the output, so the pipeline keeps taking targets while
// one result waits; it stops only when both buffer slots hold untaken
// results. Link lengths are written through cfg_ch (index 0 first link,
// 1 second link, others ignored), reset to 0.8, and must only change while
// no word is in flight.
module two_link_arm_inverse_kinematics #(
  parameter int COORD_BITS = tlik_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = tlik_pkg::ANGLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tlik_in_if.sink    in_ch,
  tlik_out_if.source out_ch,
  tlik_cfg_if.sink   cfg_ch
);
  import tlik_pkg::*;

  typedef struct packed {
    logic [ANGLE_BITS-1:0]        a0;
    logic [ANGLE_BITS-1:0]        a1;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic signed [COORD_BITS-1:0] tx;
    logic signed [COORD_BITS-1:0] ty;
    logic                         reach;
  } res_t;

  // link lengths
  logic [LEN_W-1:0] len1_r, len2_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r <= LEN_RESET;
      len2_r <= LEN_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_FIRST_LINK_LENGTH:  len1_r <= cfg_ch.data;
        CFG_SECOND_LINK_LENGTH: len2_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output buffer has a free slot
  logic [1:0] cnt_r;
  logic       en, push, pop;
  logic       core_v;
  res_t       core_res;

  assign en          = (cnt_r != 2'd2);
  assign in_ch.ready = en;

  tlik_pipe #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .in_valid         (in_ch.valid),
    .in_x             (in_ch.target_x),
    .in_y             (in_ch.target_y),
    .len1             (len1_r),
    .len2             (len2_r),
    .out_valid        (core_v),
    .out_first_angle  (core_res.a0),
    .out_second_angle (core_res.a1),
    .out_elbow_x      (core_res.ex),
    .out_elbow_y      (core_res.ey),
    .out_tip_x        (core_res.tx),
    .out_tip_y        (core_res.ty),
    .out_reachable    (core_res.reach)
  );

  // two-slot output buffer
  res_t buf_r [2];
  logic wr_ptr_r, rd_ptr_r;

  assign push = en && core_v;
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= core_res;
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.first_angle  = buf_r[rd_ptr_r].a0;
  assign out_ch.second_angle = buf_r[rd_ptr_r].a1;
  assign out_ch.elbow_x      = buf_r[rd_ptr_r].ex;
  assign out_ch.elbow_y      = buf_r[rd_ptr_r].ey;
  assign out_ch.tip_x        = buf_r[rd_ptr_r].tx;
  assign out_ch.tip_y        = buf_r[rd_ptr_r].ty;
  assign out_ch.reachable    = buf_r[rd_ptr_r].reach;

  // buffer bookkeeping
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("push did not grow the output buffer");

  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("buffer pointers disagree with count");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && cnt_r == 2'd1) |=> !out_ch.valid)
    else $error("last word taken but output still valid");

endmodule

`default_nettype wire

FILE: rtl/tlik_pipe.sv
// Fully pipelined IK datapath: r^2, discriminant, bit-per-stage root,
// normalize, vectoring CORDIC atan2, rotation CORDIC polar. Uses tlik_pkg.
`default_nettype none

module tlik_pipe #(
  parameter int COORD_BITS = tlik_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = tlik_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_BITS-1:0]  in_x,
  input  logic signed [COORD_BITS-1:0]  in_y,
  input  logic [tlik_pkg::LEN_W-1:0]    len1,
  input  logic [tlik_pkg::LEN_W-1:0]    len2,
  output logic                          out_valid,
  output logic [ANGLE_BITS-1:0]         out_first_angle,
  output logic [ANGLE_BITS-1:0]         out_second_angle,
  output logic signed [COORD_BITS-1:0]  out_elbow_x,
  output logic signed [COORD_BITS-1:0]  out_elbow_y,
  output logic signed [COORD_BITS-1:0]  out_tip_x,
  output logic signed [COORD_BITS-1:0]  out_tip_y,
  output logic                          out_reachable
);
  import tlik_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int SQW  = 2 * CB - 1;            // x^2
  localparam int R2W  = 2 * CB;                // x^2 + y^2
  localparam int XW   = CB + 18;               // 2*L*x
  localparam int TW   = ((XW > 34) ? XW : 34) + 1;
  localparam int CW   = (R2W > FAC_W) ? R2W : FAC_W;
  localparam int DW   = (((R2W + 1) > TW) ? (R2W + 1) : TW) + 1;
  localparam int NW0  = ((XW > (SQ_N + 1)) ? XW : (SQ_N + 1)) + 1;
  localparam int SW   = (DW > NW0) ? DW : NW0;
  localparam int MW   = SW - 1;
  localparam int NRW  = (MW > NRM_W) ? MW : NRM_W;
  localparam int SH   = $clog2(NRW);
  localparam int NST  = 104 + SH;
  localparam int EW   = ((CB > 19) ? CB : 19) + 1;
  localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  typedef struct packed {
    logic [SQW-1:0]       xx;
    logic [SQW-1:0]       yy;
    logic signed [XW-1:0] lx1;
    logic signed [XW-1:0] lx2;
    logic signed [XW-1:0] ly1;
    logic signed [XW-1:0] ly2;
    logic [31:0]          l1s;
    logic [31:0]          l2s;
    logic [16:0]          lsum;
    logic signed [16:0]   ldif;
  } sa_t;

  typedef struct packed {
    logic [R2W-1:0]       r2;
    logic [FAC_W-1:0]     p;
    logic [FAC_W-1:0]     q;
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    logic signed [XW-1:0] ly1;
    logic signed [XW-1:0] ly2;
  } sb_t;

  typedef struct packed {
    logic                 reach;
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    logic signed [XW-1:0] ly1;
    logic signed [XW-1:0] ly2;
  } side_t;

  typedef struct packed {
    side_t            sd;
    logic [FAC_W-1:0] am;
    logic [FAC_W-1:0] bm;
  } sc_t;

  typedef struct packed {
    side_t     sd;
    logic [35:0] ll;
    logic [33:0] lh;
    logic [33:0] hl;
    logic [31:0] hh;
  } sdd_t;

  typedef struct packed {
    logic [PR_W-1:0] rem;
    logic [SQ_N-1:0] root;
  } sq_t;

  typedef struct packed {
    logic           xneg;
    logic           yneg;
    logic [NRW-1:0] xm;
    logic [NRW-1:0] ym;
  } lane_t;

  typedef struct packed {
    lane_t [1:0] ln;
    logic  [1:0] zero;
    logic        reach;
  } nm_t;

  typedef struct packed {
    logic signed [XV_W-1:0] x;
    logic signed [XV_W-1:0] y;
    logic [31:0]            z;
  } vl_t;

  typedef struct packed {
    vl_t [1:0]  ln;
    logic [1:0] zero;
    logic       reach;
  } cv_t;

  typedef struct packed {
    logic signed [PV_W-1:0] x;
    logic signed [PV_W-1:0] y;
    logic signed [33:0]     z;
    logic                   flip;
  } pl_t;

  typedef struct packed {
    pl_t [1:0]                   ln;
    logic [1:0][ANGLE_BITS-1:0]  ang;
    logic                        reach;
  } pz_t;

  typedef struct packed {
    logic signed [RND_W-1:0] x;
    logic signed [RND_W-1:0] y;
  } rl_t;

  typedef struct packed {
    rl_t [1:0]                   ln;
    logic [1:0][ANGLE_BITS-1:0]  ang;
    logic                        reach;
  } ri_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] a0;
    logic [ANGLE_BITS-1:0] a1;
    logic signed [CB-1:0]  ex;
    logic signed [CB-1:0]  ey;
    logic signed [CB-1:0]  tx;
    logic signed [CB-1:0]  ty;
    logic                  reach;
  } sj_t;

  function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] a;
    a = v[SW-1] ? -v : v;
    return a[MW-1:0];
  endfunction

  function automatic logic signed [CB-1:0] sat(input logic signed [RND_W:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    if (e > SAT_HI) return SAT_HI[CB-1:0];
    if (e < SAT_LO) return SAT_LO[CB-1:0];
    return e[CB-1:0];
  endfunction

  // valid travels alongside the data
  logic [NST-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  assign out_valid = v_r[NST-1];

  // stage A: squares and link products
  sa_t                 sa_r, sa_nxt;
  logic [CB-1:0]       ax, ay;
  logic [R2W-1:0]      axx, ayy;
  logic signed [XW-2:0] m1x, m2x, m1y, m2y;

  always_comb begin
    ax  = in_x[CB-1] ? CB'(-in_x) : CB'(in_x);
    ay  = in_y[CB-1] ? CB'(-in_y) : CB'(in_y);
    axx = ax * ax;
    ayy = ay * ay;
    m1x = $signed({1'b0, len1}) * in_x;
    m2x = $signed({1'b0, len2}) * in_x;
    m1y = $signed({1'b0, len1}) * in_y;
    m2y = $signed({1'b0, len2}) * in_y;
    sa_nxt.xx   = axx[SQW-1:0];
    sa_nxt.yy   = ayy[SQW-1:0];
    sa_nxt.lx1  = {m1x, 1'b0};
    sa_nxt.lx2  = {m2x, 1'b0};
    sa_nxt.ly1  = {m1y, 1'b0};
    sa_nxt.ly2  = {m2y, 1'b0};
    sa_nxt.l1s  = len1 * len1;
    sa_nxt.l2s  = len2 * len2;
    sa_nxt.lsum = 17'(len1) + 17'(len2);
    sa_nxt.ldif = $signed(17'(len1) - 17'(len2));
  end

  always_ff @(posedge clk) if (en) sa_r <= sa_nxt;

  // stage B: r^2, (L1+L2)^2, (L1-L2)^2, denominator offsets
  sb_t                sb_r, sb_nxt;
  logic signed [33:0] qs;

  always_comb begin
    qs         = sa_r.ldif * sa_r.ldif;
    sb_nxt.r2  = R2W'(sa_r.xx) + R2W'(sa_r.yy);
    sb_nxt.p   = sa_r.lsum * sa_r.lsum;
    sb_nxt.q   = $unsigned(qs);
    sb_nxt.t0  = TW'(sa_r.lx1) + TW'($signed({1'b0, sa_r.l1s}))
                 - TW'($signed({1'b0, sa_r.l2s}));
    sb_nxt.t1  = TW'(sa_r.lx2) + TW'($signed({1'b0, sa_r.l2s}))
                 - TW'($signed({1'b0, sa_r.l1s}));
    sb_nxt.ly1 = sa_r.ly1;
    sb_nxt.ly2 = sa_r.ly2;
  end

  always_ff @(posedge clk) if (en) sb_r <= sb_nxt;

  // stage C: reach test, discriminant factors, denominators
  sc_t          sc_r, sc_nxt;
  logic [CW-1:0] r2c, pc, qc;

  always_comb begin
    r2c = CW'(sb_r.r2);
    pc  = CW'(sb_r.p);
    qc  = CW'(sb_r.q);
    sc_nxt.sd.reach = (r2c >= qc) && (r2c <= pc);
    sc_nxt.am  = sc_nxt.sd.reach ? FAC_W'(pc - r2c) : '0;
    sc_nxt.bm  = sc_nxt.sd.reach ? FAC_W'(r2c - qc) : '0;
    sc_nxt.sd.d0  = DW'($signed({1'b0, sb_r.r2})) + DW'(sb_r.t0);
    sc_nxt.sd.d1  = DW'($signed({1'b0, sb_r.r2})) + DW'(sb_r.t1);
    sc_nxt.sd.ly1 = sb_r.ly1;
    sc_nxt.sd.ly2 = sb_r.ly2;
  end

  always_ff @(posedge clk) if (en) sc_r <= sc_nxt;

  // stage D: partial products of the discriminant
  sdd_t sd_r, sd_nxt;

  always_comb begin
    sd_nxt.sd = sc_r.sd;
    sd_nxt.ll = sc_r.am[SPLIT-1:0] * sc_r.bm[SPLIT-1:0];
    sd_nxt.lh = sc_r.am[SPLIT-1:0] * sc_r.bm[FAC_W-1:SPLIT];
    sd_nxt.hl = sc_r.am[FAC_W-1:SPLIT] * sc_r.bm[SPLIT-1:0];
    sd_nxt.hh = sc_r.am[FAC_W-1:SPLIT] * sc_r.bm[FAC_W-1:SPLIT];
  end

  always_ff @(posedge clk) if (en) sd_r <= sd_nxt;

  // stage E: sum of partials, then one root bit per stage
  sq_t   sq_r [SQ_N+1];
  side_t sdq_r [SQ_N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].rem  <= PR_W'(sd_r.ll) + (PR_W'(sd_r.lh) << SPLIT)
                      + (PR_W'(sd_r.hl) << SPLIT) + (PR_W'(sd_r.hh) << (2 * SPLIT));
      sq_r[0].root <= '0;
      sdq_r[0]     <= sd_r.sd;
    end
  end

  for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
    localparam int B = SQ_N - 1 - g;
    logic [PR_W-1:0] trial;
    sq_t             nxt;

    always_comb begin
      trial = (PR_W'(sq_r[g].root) << (B + 1)) | (PR_W'(1) << (2 * B));
      nxt   = sq_r[g];
      if (sq_r[g].rem >= trial) begin
        nxt.rem  = sq_r[g].rem - trial;
        nxt.root = sq_r[g].root | (SQ_N'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[g+1]  <= nxt;
        sdq_r[g+1] <= sdq_r[g];
      end
    end
  end

  // stage F: numerators, sign and magnitude of each atan2 pair
  nm_t nm_r [SH+1];
  nm_t nf_nxt;
  logic signed [SW-1:0] n0, n1, e0, e1, sx;

  always_comb begin
    sx = $signed({{(SW - SQ_N){1'b0}}, sq_r[SQ_N].root});
    n0 = SW'(sdq_r[SQ_N].ly1) - sx;
    n1 = SW'(sdq_r[SQ_N].ly2) + sx;
    e0 = SW'(sdq_r[SQ_N].d0);
    e1 = SW'(sdq_r[SQ_N].d1);
    nf_nxt.ln[0].yneg = n0[SW-1];
    nf_nxt.ln[0].xneg = e0[SW-1];
    nf_nxt.ln[0].ym   = NRW'(mag(n0));
    nf_nxt.ln[0].xm   = NRW'(mag(e0));
    nf_nxt.ln[1].yneg = n1[SW-1];
    nf_nxt.ln[1].xneg = e1[SW-1];
    nf_nxt.ln[1].ym   = NRW'(mag(n1));
    nf_nxt.ln[1].xm   = NRW'(mag(e1));
    nf_nxt.zero[0]    = (n0 == '0) && (e0 == '0);
    nf_nxt.zero[1]    = (n1 == '0) && (e1 == '0);
    nf_nxt.reach      = sdq_r[SQ_N].reach;
  end

  always_ff @(posedge clk) if (en) nm_r[0] <= nf_nxt;

  // normalize: left shift by halving steps until the top bit is set
  for (genvar j = 0; j < SH; j++) begin : g_norm
    localparam int S = 2 ** (SH - 1 - j);
    nm_t            nxt;
    logic [NRW-1:0] m [2];

    always_comb begin
      nxt = nm_r[j];
      for (int k = 0; k < 2; k++) begin
        m[k] = nm_r[j].ln[k].xm | nm_r[j].ln[k].ym;
        if (m[k][NRW-1 -: S] == '0) begin
          nxt.ln[k].xm = nm_r[j].ln[k].xm << S;
          nxt.ln[k].ym = nm_r[j].ln[k].ym << S;
        end
      end
    end

    always_ff @(posedge clk) if (en) nm_r[j+1] <= nxt;
  end

  // stage G: take 39 bits, fold the left half plane
  cv_t cv_r [CORDIC_N+1];
  cv_t cg_nxt;
  logic [NRM_W-1:0] xn [2];
  logic [NRM_W-1:0] yn [2];
  logic             fl [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      xn[k] = nm_r[SH].ln[k].xm[NRW-1 -: NRM_W];
      yn[k] = nm_r[SH].ln[k].ym[NRW-1 -: NRM_W];
      fl[k] = nm_r[SH].ln[k].xneg && (xn[k] != '0);
      cg_nxt.ln[k].x = $signed(XV_W'(xn[k]));
      cg_nxt.ln[k].y = (nm_r[SH].ln[k].yneg ^ fl[k]) ? -$signed(XV_W'(yn[k]))
                                                      : $signed(XV_W'(yn[k]));
      cg_nxt.ln[k].z = fl[k] ? 32'h8000_0000 : 32'h0;
    end
    cg_nxt.zero  = nm_r[SH].zero;
    cg_nxt.reach = nm_r[SH].reach;
  end

  always_ff @(posedge clk) if (en) cv_r[0] <= cg_nxt;

  // vectoring CORDIC
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_vec
    cv_t                    nxt;
    logic signed [XV_W-1:0] dx [2];
    logic signed [XV_W-1:0] dy [2];

    always_comb begin
      nxt = cv_r[i];
      for (int k = 0; k < 2; k++) begin
        dx[k] = cv_r[i].ln[k].y >>> i;
        dy[k] = cv_r[i].ln[k].x >>> i;
        if (cv_r[i].ln[k].y[XV_W-1]) begin
          nxt.ln[k].x = cv_r[i].ln[k].x - dx[k];
          nxt.ln[k].y = cv_r[i].ln[k].y + dy[k];
          nxt.ln[k].z = cv_r[i].ln[k].z - atan_tab(i);
        end else begin
          nxt.ln[k].x = cv_r[i].ln[k].x + dx[k];
          nxt.ln[k].y = cv_r[i].ln[k].y - dy[k];
          nxt.ln[k].z = cv_r[i].ln[k].z + atan_tab(i);
        end
      end
    end

    always_ff @(posedge clk) if (en) cv_r[i+1] <= nxt;
  end

  // stage H: double the half angle, round the output angle, seed rotation
  pz_t pz_r [CORDIC_N+1];
  pz_t ph_nxt;
  logic [31:0] ang32 [2];
  logic [32:0] rsum  [2];
  logic [47:0] seed  [2];
  logic        hflip [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ang32[k] = cv_r[CORDIC_N].zero[k] ? 32'h0 : {cv_r[CORDIC_N].ln[k].z[30:0], 1'b0};
      rsum[k]  = {1'b0, ang32[k]} + (33'd1 << (31 - ANGLE_BITS));
      ph_nxt.ang[k] = rsum[k][31 -: ANGLE_BITS];
      hflip[k] = ($signed(ang32[k]) > 32'sd1073741824)
                 || ($signed(ang32[k]) < -32'sd1073741824);
      seed[k]  = (k == 0 ? len1 : len2) * INV_GAIN;
      ph_nxt.ln[k].x    = PV_W'($signed({1'b0, seed[k]}));
      ph_nxt.ln[k].y    = '0;
      ph_nxt.ln[k].z    = 34'($signed(ang32[k] ^ (hflip[k] ? 32'h8000_0000 : 32'h0)));
      ph_nxt.ln[k].flip = hflip[k];
    end
    ph_nxt.reach = cv_r[CORDIC_N].reach;
  end

  always_ff @(posedge clk) if (en) pz_r[0] <= ph_nxt;

  // rotation CORDIC
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
    pz_t                    nxt;
    logic signed [PV_W-1:0] dx [2];
    logic signed [PV_W-1:0] dy [2];

    always_comb begin
      nxt = pz_r[i];
      for (int k = 0; k < 2; k++) begin
        dx[k] = pz_r[i].ln[k].y >>> i;
        dy[k] = pz_r[i].ln[k].x >>> i;
        if (!pz_r[i].ln[k].z[33]) begin
          nxt.ln[k].x = pz_r[i].ln[k].x - dx[k];
          nxt.ln[k].y = pz_r[i].ln[k].y + dy[k];
          nxt.ln[k].z = pz_r[i].ln[k].z - $signed({2'b00, atan_tab(i)});
        end else begin
          nxt.ln[k].x = pz_r[i].ln[k].x + dx[k];
          nxt.ln[k].y = pz_r[i].ln[k].y - dy[k];
          nxt.ln[k].z = pz_r[i].ln[k].z + $signed({2'b00, atan_tab(i)});
        end
      end
    end

    always_ff @(posedge clk) if (en) pz_r[i+1] <= nxt;
  end

  // stage I: undo the half-turn fold, round to 14 fraction bits
  ri_t ri_r, ri_nxt;
  logic signed [PV_W-1:0] fx [2];
  logic signed [PV_W-1:0] fy [2];
  logic signed [PV_W-1:0] rx [2];
  logic signed [PV_W-1:0] ry [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      fx[k] = pz_r[CORDIC_N].ln[k].flip ? -pz_r[CORDIC_N].ln[k].x : pz_r[CORDIC_N].ln[k].x;
      fy[k] = pz_r[CORDIC_N].ln[k].flip ? -pz_r[CORDIC_N].ln[k].y : pz_r[CORDIC_N].ln[k].y;
      rx[k] = fx[k] + (PV_W'(1) <<< 31);
      ry[k] = fy[k] + (PV_W'(1) <<< 31);
      ri_nxt.ln[k].x = rx[k][PV_W-1:32];
      ri_nxt.ln[k].y = ry[k][PV_W-1:32];
    end
    ri_nxt.ang   = pz_r[CORDIC_N].ang;
    ri_nxt.reach = pz_r[CORDIC_N].reach;
  end

  always_ff @(posedge clk) if (en) ri_r <= ri_nxt;

  // stage J: tip sum and saturation
  sj_t sj_r, sj_nxt;

  always_comb begin
    sj_nxt.a0    = ri_r.ang[0];
    sj_nxt.a1    = ri_r.ang[1];
    sj_nxt.ex    = sat((RND_W + 1)'(ri_r.ln[0].x));
    sj_nxt.ey    = sat((RND_W + 1)'(ri_r.ln[0].y));
    sj_nxt.tx    = sat((RND_W + 1)'(ri_r.ln[0].x) + (RND_W + 1)'(ri_r.ln[1].x));
    sj_nxt.ty    = sat((RND_W + 1)'(ri_r.ln[0].y) + (RND_W + 1)'(ri_r.ln[1].y));
    sj_nxt.reach = ri_r.reach;
  end

  always_ff @(posedge clk) if (en) sj_r <= sj_nxt;

  assign out_first_angle  = sj_r.a0;
  assign out_second_angle = sj_r.a1;
  assign out_elbow_x      = sj_r.ex;
  assign out_elbow_y      = sj_r.ey;
  assign out_tip_x        = sj_r.tx;
  assign out_tip_y        = sj_r.ty;
  assign out_reachable    = sj_r.reach;

endmodule

`default_nettype wire

FILE: test/two_link_arm_inverse_kinematics_checker.sv
// Result checker for the two-link arm IK block: watches the target, result
// and config channels, predicts each result and compares it as a whole word.
// Depends on tlik_pkg and the tlik_if channel interfaces.
`timescale 1ns / 100ps

module two_link_arm_inverse_kinematics_checker (
  input  logic clk,
  input  logic rst_n,
  tlik_in_if   in_ch,
  tlik_out_if  out_ch,
  tlik_cfg_if  cfg_ch,
  output int   errors,
  output int   pending
);
  import tlik_pkg::*;

  typedef struct packed {
    logic [15:0]        first_angle;
    logic [15:0]        second_angle;
    logic signed [17:0] elbow_x;
    logic signed [17:0] elbow_y;
    logic signed [17:0] tip_x;
    logic signed [17:0] tip_y;
    logic               reachable;
  } arm_pose_t;

  localparam int unsigned ARCTAN [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1};

  logic [15:0] link1, link2;
  arm_pose_t   expected_poses[$];

  // 2*atan2(num, den) as a 32-bit binary angle via vectoring CORDIC
  function automatic logic [31:0] doubled_atan(input longint num, input longint den);
    longint ym, xm, m, x, y, dx, dy;
    int h;
    logic [31:0] z;
    ym = num < 0 ? -num : num;
    xm = den < 0 ? -den : den;
    m = xm | ym;
    if (m == 0) return 32'd0;
    h = 63;
    while (!m[h]) h--;
    if (h > 38) begin
      xm = xm >> (h - 38);
      ym = ym >> (h - 38);
    end else begin
      xm = xm << (38 - h);
      ym = ym << (38 - h);
    end
    x = den < 0 ? -xm : xm;
    y = num < 0 ? -ym : ym;
    z = 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    return z << 1;
  endfunction

  // len * (cos, sin) of a binary angle, rounded to 14 fraction bits
  function automatic void link_vector(input logic [31:0] ang, input longint len,
                                      output longint cx, output longint sy);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed(ang));
    x = len * 64'd2608131497;
    y = 0;
    flip = 0;
    if (z > (64'sd1 << 30)) begin
      z -= 64'sd1 << 31; flip = 1;
    end else if (z < -(64'sd1 << 30)) begin
      z += 64'sd1 << 31; flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cx = (x + (64'sd1 << 31)) >>> 32;
    sy = (y + (64'sd1 << 31)) >>> 32;
  endfunction

  function automatic longint clamp_coord(input longint v);
    return v > 131071 ? 131071 : (v < -131072 ? -131072 : v);
  endfunction

  function automatic logic [15:0] to_angle16(input logic [31:0] a);
    logic [32:0] r;
    r = {1'b0, a} + 33'd32768;
    return r[31:16];
  endfunction

  function automatic arm_pose_t solve_arm(input logic signed [17:0] tx,
                                          input logic signed [17:0] ty,
                                          input logic [15:0] len1,
                                          input logic [15:0] len2);
    longint x, y, a, b, r2, p, q, s, n0, n1, d0, d1, ex, ey, fx, fy;
    logic [71:0] prod, cc;
    logic [35:0] root, c;
    logic [31:0] a0, a1;
    arm_pose_t res;
    x = tx; y = ty; a = len1; b = len2;
    r2 = x * x + y * y;
    p = (a + b) * (a + b);
    q = (a - b) * (a - b);
    res.reachable = (r2 >= q) && (r2 <= p);
    root = '0;
    if (res.reachable) begin
      prod = 72'(p - r2) * 72'(r2 - q);
      for (int i = 35; i >= 0; i--) begin
        c = root | (36'd1 << i);
        cc = 72'(c) * 72'(c);
        if (cc <= prod) root = c;
      end
    end
    s = longint'(root);
    n0 = 2 * a * y - s;
    n1 = 2 * b * y + s;
    d0 = r2 + 2 * a * x + a * a - b * b;
    d1 = r2 + 2 * b * x + b * b - a * a;
    a0 = doubled_atan(n0, d0);
    a1 = doubled_atan(n1, d1);
    link_vector(a0, a, ex, ey);
    link_vector(a1, b, fx, fy);
    res.first_angle  = to_angle16(a0);
    res.second_angle = to_angle16(a1);
    res.tip_x   = 18'(clamp_coord(ex + fx));
    res.tip_y   = 18'(clamp_coord(ey + fy));
    res.elbow_x = 18'(clamp_coord(ex));
    res.elbow_y = 18'(clamp_coord(ey));
    return res;
  endfunction

  assign pending = expected_poses.size();

  always @(posedge clk) begin
    arm_pose_t got, want;
    if (!rst_n) begin
      link1 <= LEN_RESET;
      link2 <= LEN_RESET;
      expected_poses.delete();
      errors <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_FIRST_LINK_LENGTH) link1 <= cfg_ch.data;
        else if (cfg_ch.index == CFG_SECOND_LINK_LENGTH) link2 <= cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready)
        expected_poses.push_back(solve_arm(in_ch.target_x, in_ch.target_y, link1, link2));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.first_angle, out_ch.second_angle, out_ch.elbow_x, out_ch.elbow_y,
                out_ch.tip_x, out_ch.tip_y, out_ch.reachable};
        if (expected_poses.size() == 0) begin
          if (errors < 10) $display("unexpected result word %p", got);
          errors <= errors + 1;
        end else begin
          want = expected_poses.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("mismatch: expected %p got %p", want, got);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

FILE: test/two_link_arm_inverse_kinematics_test.sv
// Top of the two-link arm IK testbench: clock, reset, target and config
// stimulus, receiver backpressure and the verdict. Uses tlik_pkg, tlik_if
// and two_link_arm_inverse_kinematics_checker.
`timescale 1ns / 100ps

module two_link_arm_inverse_kinematics_test;
  import tlik_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   errors, pending;

  // idle percentages of sender and receiver; long_hold stalls the receiver
  int   send_idle = 29;
  int   recv_idle = 76;
  logic long_hold = 0;
  logic hold_req = 0;

  tlik_in_if  in_ch ();
  tlik_out_if out_ch ();
  tlik_cfg_if cfg_ch ();

  two_link_arm_inverse_kinematics dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  two_link_arm_inverse_kinematics_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_FIRST_LINK_LENGTH;
    cfg_ch.data = '0;
  end

  // receiver: random stalls, or a solid hold while long_hold is up
  always @(posedge clk)
    out_ch.ready <= rst_n && !long_hold && ($urandom_range(99) >= recv_idle);

  // long stall counted in cycles, sender keeps offering words meanwhile
  initial begin
    wait (hold_req);
    @(posedge clk);
    long_hold <= 1;
    repeat (400) @(posedge clk);
    long_hold <= 0;
  end

  initial begin
    #20_000_000;
    $display("** two_link_arm_inverse_kinematics: FAILED **");
    $finish;
  end

  // offer one target word, idling at random first; returns once accepted
  task automatic send_target(input logic signed [17:0] x, input logic signed [17:0] y);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.target_x <= x;
    in_ch.target_y <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // link lengths change only with nothing in flight: drain, then pipeline depth
  task automatic write_links(input logic [15:0] len1, input logic [15:0] len2);
    in_ch.valid <= 0;
    wait (pending == 0);
    repeat (120) @(posedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= CFG_FIRST_LINK_LENGTH;
    cfg_ch.data <= len1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= CFG_SECOND_LINK_LENGTH;
    cfg_ch.data <= len2;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  // mostly targets inside the workspace box, the rest over the full range
  task automatic random_targets(input int count, input logic [15:0] len1,
                                input logic [15:0] len2);
    int span;
    logic signed [17:0] x, y;
    span = int'(len1) + int'(len2);
    if (span > 131071) span = 131071;
    repeat (count) begin
      if ($urandom_range(9) < 7) begin
        x = 18'($signed($urandom_range(2 * span)) - span);
        y = 18'($signed($urandom_range(2 * span)) - span);
      end else begin
        x = 18'($urandom);
        y = 18'($urandom);
      end
      send_target(x, y);
    end
  endtask

  initial begin
    logic [15:0] l1s [6];
    logic [15:0] l2s [6];
    logic [15:0] len1, len2;
    l1s = '{13107, 65535, 0, 65535, 0, 9000};
    l2s = '{13107, 65535, 0, 0, 65535, 20000};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: origin, coordinate extremes, full stretch, folded, on-axis
    send_target(0, 0);
    send_target(18'sd131071, 18'sd131071);
    send_target(-18'sd131072, -18'sd131072);
    send_target(18'sd131071, -18'sd131072);
    send_target(-18'sd131072, 18'sd131071);
    send_target(18'sd131071, 0);
    send_target(-18'sd131072, 0);
    send_target(0, 18'sd131071);
    send_target(0, -18'sd131072);
    send_target(18'sd26214, 0);      // fully stretched: r2 equals P
    send_target(-18'sd26214, 0);     // stretched along negative x
    send_target(0, 18'sd26214);
    send_target(18'sd26215, 0);      // just out of reach
    send_target(-18'sd13107, 0);     // on the negative x axis at one link length
    send_target(18'sd13107, 18'sd13107);
    send_target(-18'sd1, 18'sd1);

    // random phases across link settings: extremes, zero links, uneven links
    for (int ph = 0; ph < 6; ph++) begin
      len1 = l1s[ph];
      len2 = l2s[ph];
      if (ph > 0) write_links(len1, len2);
      if (ph == 2) begin
        send_target(0, 0);   // zero links at the origin: zero over zero
        send_target(18'sd5, -18'sd3);
      end
      if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
        hold_req <= 1;
      end else if (ph == 2) begin
        send_idle = 76;
        recv_idle = 29;
      end
      random_targets(80, len1, len2);
    end
    in_ch.valid <= 0;

    wait (pending == 0);
    repeat (150) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("** two_link_arm_inverse_kinematics: PASSED **");
    else
      $display("** two_link_arm_inverse_kinematics: FAILED **");
    $finish;
  end
endmodule
